// ----- hw/rtl/coin_change_min_coins_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the coin change block
// Wrap concurrent assertions with a common clock, reset and report style.
// ----------------------------------------------------------------------------
`ifndef COIN_CHANGE_MIN_COINS_ASSERT_SVH
`define COIN_CHANGE_MIN_COINS_ASSERT_SVH

// Assert a property on a given clock, disabled while reset is active
`define CCMC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assert a property on the block clock and reset
`define CCMC_ASSERT(lbl, prop, msg) `CCMC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/ccmc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccmc_pkg
// Shared constants, codes and types of the minimum-coin change maker.
// ----------------------------------------------------------------------------
package ccmc_pkg;

  // Sizing
  localparam int MAX_COINS  = 8;
  localparam int MAX_AMOUNT = 63;

  // Fixed field widths of the request and result
  localparam int COIN_W    = 6;
  localparam int SLOT_IN_W = 3;
  localparam int AMT_IN_W  = 6;

  // Derived widths
  localparam int AMT_W     = (MAX_AMOUNT > 0) ? $clog2(MAX_AMOUNT + 1) : 1;
  localparam int CNT_W     = $clog2(MAX_AMOUNT + 3);
  localparam int SLOT_W    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int ENTRY_W   = CNT_W + COIN_W;
  localparam int TBL_DEPTH = MAX_AMOUNT + 1;

  // Request commands
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SOLVE = 1'b1
  } cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_INIT   = 7'b000_0010,
    S_FILL   = 7'b000_0100,
    S_WRITE  = 7'b000_1000,
    S_BT_RD  = 7'b001_0000,
    S_BT_CHK = 7'b010_0000,
    S_EMIT   = 7'b100_0000
  } state_e;

  // Relaxation unit operands and outcome
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] base_cnt;
    logic [CNT_W-1:0] best_cnt;
  } relax_req_t;

  typedef struct packed {
    logic             take;
    logic [CNT_W-1:0] cand;
  } relax_rsp_t;

endpackage

// ----- hw/rtl/coin_change_min_coins.sv -----
// Load request: the slot is written and the block stays ready for the next request.
// Solve request for amount Y: the table is built by seeding entry zero, then MAX_COINS
// slot reads plus one entry write per sub-amount; each coin then takes a read, a check and
// a result step, and the result is held while the output is stalled. Amount zero goes
// straight to its result. One request at a time; input stalls until the last result.
// Reset clears the denominations and the sequencer; tables need no clearing.
// ----------------------------------------------------------------------------
// coin_change_min_coins
// Minimum-coin change maker: builds the count table by dynamic programming
// on a shared relaxation unit, then backtracks the coins of the solution.
// ----------------------------------------------------------------------------
`include "coin_change_min_coins_assert.svh"

module coin_change_min_coins (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [ccmc_pkg::SLOT_IN_W-1:0] slot_i,
  input  logic [ccmc_pkg::COIN_W-1:0]    coin_in_i,
  input  logic [ccmc_pkg::AMT_IN_W-1:0]  amount_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ccmc_pkg::COIN_W-1:0]    coin_out_o,
  output logic                           found_o,
  output logic                           last_o
);

  ccmc_pkg::state_e state_q, state_d;

  logic [ccmc_pkg::COIN_W-1:0] denom_q [ccmc_pkg::MAX_COINS];
  logic                        denom_we;
  logic [ccmc_pkg::SLOT_W-1:0] denom_waddr;

  logic [ccmc_pkg::AMT_W-1:0]  y_q, y_d;
  logic [ccmc_pkg::AMT_W-1:0]  i_q, i_d;
  logic [ccmc_pkg::AMT_W-1:0]  cur_q, cur_d;
  logic [ccmc_pkg::SLOT_W-1:0] j_q, j_d;
  logic [ccmc_pkg::CNT_W-1:0]  best_cnt_q, best_cnt_d;
  logic [ccmc_pkg::COIN_W-1:0] best_coin_q, best_coin_d;
  logic                        pend_vld_q, pend_vld_d;
  logic [ccmc_pkg::COIN_W-1:0] pend_coin_q, pend_coin_d;
  logic [ccmc_pkg::COIN_W-1:0] out_coin_q, out_coin_d;
  logic                        out_found_q, out_found_d;
  logic                        out_last_q, out_last_d;

  // Table RAM port signals
  logic                         tbl_we;
  logic [ccmc_pkg::AMT_W-1:0]   tbl_waddr;
  logic [ccmc_pkg::ENTRY_W-1:0] tbl_wdata;
  logic [ccmc_pkg::AMT_W-1:0]   tbl_raddr;
  logic [ccmc_pkg::ENTRY_W-1:0] tbl_rdata;

  ccmc_pkg::relax_req_t relax_req;
  ccmc_pkg::relax_rsp_t relax_rsp;

  logic [ccmc_pkg::COIN_W-1:0] slot_coin;
  logic                        slot_ok;
  logic [ccmc_pkg::CNT_W-1:0]  best_new_cnt;
  logic [ccmc_pkg::COIN_W-1:0] best_new_coin;
  logic [ccmc_pkg::CNT_W-1:0]  cnt_init;
  logic [ccmc_pkg::COIN_W-1:0] bt_coin;
  logic                        bt_ok;
  logic [ccmc_pkg::AMT_W-1:0]  bt_rem;
  logic                        in_acc;

  // Count table and last-coin table share one RAM word
  ccmc_ram #(
    .Width (ccmc_pkg::ENTRY_W),
    .Depth (ccmc_pkg::TBL_DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Relax the current entry with the sub-amount whose read was issued in the cycle before
  assign relax_req.vld      = pend_vld_q;
  assign relax_req.base_cnt = tbl_rdata[ccmc_pkg::ENTRY_W-1:ccmc_pkg::COIN_W];
  assign relax_req.best_cnt = best_cnt_q;

  ccmc_relax u_relax (
    .req_i (relax_req),
    .rsp_o (relax_rsp)
  );

  assign best_new_cnt  = relax_rsp.take ? relax_rsp.cand : best_cnt_q;
  assign best_new_coin = relax_rsp.take ? pend_coin_q : best_coin_q;
  assign cnt_init      = ccmc_pkg::CNT_W'(int'(y_q) + 1);

  // Slot under test in the fill loop
  assign slot_coin = denom_q[j_q];
  assign slot_ok   = (slot_coin != '0) && (int'(slot_coin) <= int'(i_q));

  // Backtrack step
  assign bt_coin = tbl_rdata[ccmc_pkg::COIN_W-1:0];
  assign bt_ok   = (bt_coin != '0) && (int'(bt_coin) <= int'(cur_q));
  assign bt_rem  = ccmc_pkg::AMT_W'(int'(cur_q) - int'(bt_coin));

  assign in_stall_o = (state_q != ccmc_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    y_d         = y_q;
    i_d         = i_q;
    cur_d       = cur_q;
    j_d         = j_q;
    best_cnt_d  = best_cnt_q;
    best_coin_d = best_coin_q;
    pend_vld_d  = 1'b0;
    pend_coin_d = pend_coin_q;
    out_coin_d  = out_coin_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;
    denom_we    = 1'b0;
    denom_waddr = ccmc_pkg::SLOT_W'(slot_i);
    tbl_we      = 1'b0;
    tbl_waddr   = i_q;
    tbl_wdata   = {best_new_cnt, best_new_coin};
    tbl_raddr   = cur_q;

    unique case (state_q)
      ccmc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == ccmc_pkg::CMD_LOAD) begin
            // Write the slot, drop loads beyond the slot count
            denom_we = (int'(slot_i) < ccmc_pkg::MAX_COINS);
          end else if (int'(amount_i) > ccmc_pkg::MAX_AMOUNT) begin
            out_coin_d  = '0;
            out_found_d = 1'b0;
            out_last_d  = 1'b1;
            state_d     = ccmc_pkg::S_EMIT;
          end else if (amount_i == '0) begin
            out_coin_d  = '0;
            out_found_d = 1'b1;
            out_last_d  = 1'b1;
            cur_d       = '0;
            state_d     = ccmc_pkg::S_EMIT;
          end else begin
            y_d     = ccmc_pkg::AMT_W'(amount_i);
            state_d = ccmc_pkg::S_INIT;
          end
        end
      end

      ccmc_pkg::S_INIT: begin
        // Seed entry zero, open the first sub-amount
        tbl_we      = 1'b1;
        tbl_waddr   = '0;
        tbl_wdata   = '0;
        i_d         = ccmc_pkg::AMT_W'(1);
        j_d         = '0;
        best_cnt_d  = cnt_init;
        best_coin_d = '0;
        state_d     = ccmc_pkg::S_FILL;
      end

      ccmc_pkg::S_FILL: begin
        // Issue the read for this slot, relax with the previous slot
        tbl_raddr   = ccmc_pkg::AMT_W'(int'(i_q) - int'(slot_coin));
        pend_vld_d  = slot_ok;
        pend_coin_d = slot_coin;
        best_cnt_d  = best_new_cnt;
        best_coin_d = best_new_coin;
        if (j_q == ccmc_pkg::SLOT_W'(ccmc_pkg::MAX_COINS - 1)) begin
          state_d = ccmc_pkg::S_WRITE;
        end else begin
          j_d = j_q + ccmc_pkg::SLOT_W'(1);
        end
      end

      ccmc_pkg::S_WRITE: begin
        // Relax with the last slot and store the entry
        tbl_we = 1'b1;
        if (i_q == y_q) begin
          if (int'(best_new_cnt) > int'(y_q)) begin
            out_coin_d  = '0;
            out_found_d = 1'b0;
            out_last_d  = 1'b1;
            state_d     = ccmc_pkg::S_EMIT;
          end else begin
            cur_d   = y_q;
            state_d = ccmc_pkg::S_BT_RD;
          end
        end else begin
          i_d         = i_q + ccmc_pkg::AMT_W'(1);
          j_d         = '0;
          best_cnt_d  = cnt_init;
          best_coin_d = '0;
          state_d     = ccmc_pkg::S_FILL;
        end
      end

      ccmc_pkg::S_BT_RD: begin
        tbl_raddr = cur_q;
        state_d   = ccmc_pkg::S_BT_CHK;
      end

      ccmc_pkg::S_BT_CHK: begin
        // Emit the recorded coin and step back by it, or emit not-found if it is unusable
        if (bt_ok) begin
          out_coin_d  = bt_coin;
          out_found_d = 1'b1;
          out_last_d  = (bt_rem == '0);
          cur_d       = bt_rem;
        end else begin
          out_coin_d  = '0;
          out_found_d = 1'b0;
          out_last_d  = 1'b1;
        end
        state_d = ccmc_pkg::S_EMIT;
      end

      ccmc_pkg::S_EMIT: begin
        // Hold the result until it is taken
        if (!out_stall_i) begin
          state_d = out_last_q ? ccmc_pkg::S_IDLE : ccmc_pkg::S_BT_RD;
        end
      end

      default: begin
        state_d = ccmc_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ccmc_pkg::S_IDLE;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Denomination slots, cleared to unused on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ccmc_pkg::MAX_COINS; k++) begin
        denom_q[k] <= '0;
      end
    end else if (denom_we) begin
      denom_q[denom_waddr] <= coin_in_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    y_q         <= y_d;
    i_q         <= i_d;
    cur_q       <= cur_d;
    j_q         <= j_d;
    best_cnt_q  <= best_cnt_d;
    best_coin_q <= best_coin_d;
    pend_coin_q <= pend_coin_d;
    out_coin_q  <= out_coin_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = (state_q == ccmc_pkg::S_EMIT);
  assign coin_out_o  = out_coin_q;
  assign found_o     = out_found_q;
  assign last_o      = out_last_q;

  // A not-found result is a lone empty final result
  `CCMC_ASSERT(a_notfound_empty,
    out_valid_o && !found_o |-> (coin_out_o == '0) && last_o, "not-found result malformed")
  // The fill loop stays within 1..Y
  `CCMC_ASSERT(a_fill_range,
    (state_q == ccmc_pkg::S_FILL) |-> (i_q != '0) && (i_q <= y_q), "fill index out of range")
  // A found final coin leaves nothing to pay
  `CCMC_ASSERT(a_last_zero,
    out_valid_o && found_o && last_o |-> (cur_q == '0), "final coin leaves a remainder")
  // A found coin that is not final leaves a remainder
  `CCMC_ASSERT(a_mid_nonzero,
    out_valid_o && found_o && !last_o |-> (cur_q != '0), "early coin clears the amount")

endmodule

// ----- hw/rtl/ccmc_ram.sv -----
// ----------------------------------------------------------------------------
// ccmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ccmc_relax.sv -----
// ----------------------------------------------------------------------------
// ccmc_relax
// Shared add-and-compare unit: proposes count + 1 and keeps it only when
// it is strictly below the best count found so far.
// ----------------------------------------------------------------------------
module ccmc_relax (
  input  ccmc_pkg::relax_req_t req_i,
  output ccmc_pkg::relax_rsp_t rsp_o
);

  logic [ccmc_pkg::CNT_W-1:0] cand;

  // Add one coin to the smaller sub-amount
  assign cand = req_i.base_cnt + ccmc_pkg::CNT_W'(1);

  // Take only a strictly smaller count
  assign rsp_o.cand = cand;
  assign rsp_o.take = req_i.vld && (cand < req_i.best_cnt);

endmodule

// ----- tb/sv/coin_change_min_coins_tb.sv -----
// ----------------------------------------------------------------------------
// coin_change_min_coins_tb
// Self-checking bench for the minimum-coin change maker. Loads denominations,
// issues solve requests and predicts every returned coin with a local
// dynamic-programming change maker. Returned coins are compared field by
// field in order. Both handshakes are throttled at random, apart from a
// stretch that runs at full rate.
// ----------------------------------------------------------------------------
module coin_change_min_coins_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RESULTS  = 63;
  localparam int RANDOM_ITEMS = 430;
  localparam int DRAIN_CYCLES = 700;
  // Slowest run: every request a full-table solve of up to 63 coins, plus stalled coins
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [ccmc_pkg::COIN_W-1:0] coin;
    logic                        found;
    logic                        last;
  } change_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic                           cmd_i       = ccmc_pkg::CMD_LOAD;
  logic [ccmc_pkg::SLOT_IN_W-1:0] slot_i      = '0;
  logic [ccmc_pkg::COIN_W-1:0]    coin_in_i   = '0;
  logic [ccmc_pkg::AMT_IN_W-1:0]  amount_i    = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [ccmc_pkg::COIN_W-1:0]    coin_out_o;
  logic                           found_o;
  logic                           last_o;

  logic [ccmc_pkg::COIN_W-1:0] purse [ccmc_pkg::MAX_COINS];
  change_t                     change_q [$];
  int                          errors      = 0;
  int                          cycle_count = 0;
  bit                          steady      = 1'b0;

  coin_change_min_coins i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .slot_i      (slot_i),
    .coin_in_i   (coin_in_i),
    .amount_i    (amount_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .coin_out_o  (coin_out_o),
    .found_o     (found_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Append one expected coin
  function automatic void push_change(input logic [ccmc_pkg::COIN_W-1:0] coin,
                                      input logic found, input logic last);
    change_q.insert(change_q.size(), change_t'{coin: coin, found: found, last: last});
  endfunction

  // Rebuild the minimum-count table up to the target and backtrack the coins
  function automatic void predict_change(input logic [ccmc_pkg::AMT_IN_W-1:0] target);
    int unsigned                 fewest [ccmc_pkg::MAX_AMOUNT + 1];
    logic [ccmc_pkg::COIN_W-1:0] tail [ccmc_pkg::MAX_AMOUNT + 1];
    change_t                     coins [$];
    int unsigned                 y, cur, c, cand, i, j;
    y = 32'(target);
    if (y > ccmc_pkg::MAX_AMOUNT) begin
      push_change('0, 1'b0, 1'b1);
      return;
    end
    if (y == 0) begin
      push_change('0, 1'b1, 1'b1);
      return;
    end
    fewest[0] = 0;
    tail[0]   = '0;
    for (i = 1; i <= y; i++) begin
      fewest[i] = y + 1;
      tail[i]   = '0;
      // Try slots in ascending order; only a strictly smaller count wins
      for (j = 0; j < ccmc_pkg::MAX_COINS; j++) begin
        c = 32'(purse[j]);
        if (c != 0 && c <= i) begin
          cand = fewest[i - c] + 1;
          if (cand < fewest[i]) begin
            fewest[i] = cand;
            tail[i]   = purse[j];
          end
        end
      end
    end
    if (fewest[y] > y) begin
      push_change('0, 1'b0, 1'b1);
      return;
    end
    // Walk back from the target along the recorded last coins
    cur = y;
    while (cur > 0 && coins.size() < MAX_RESULTS) begin
      c = 32'(tail[cur]);
      if (c == 0 || c > cur) break;
      cur -= c;
      coins.insert(coins.size(),
                   change_t'{coin: tail[cur + c], found: 1'b1, last: (cur == 0)});
    end
    if (coins.size() == 0) begin
      push_change('0, 1'b0, 1'b1);
      return;
    end
    coins[coins.size() - 1].last = 1'b1;
    foreach (coins[k]) change_q.insert(change_q.size(), coins[k]);
  endfunction

  // Send one request, idling at random first; valid stays high once accepted
  task automatic send_request(input ccmc_pkg::cmd_e cmd,
                              input logic [ccmc_pkg::SLOT_IN_W-1:0] slot,
                              input logic [ccmc_pkg::COIN_W-1:0] coin,
                              input logic [ccmc_pkg::AMT_IN_W-1:0] amount);
    while (!steady && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    slot_i     <= slot;
    coin_in_i  <= coin;
    amount_i   <= amount;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd == ccmc_pkg::CMD_LOAD) begin
      if (slot < ccmc_pkg::MAX_COINS) purse[slot] = coin;
    end else begin
      predict_change(amount);
    end
  endtask

  // Empty purse: only amount zero can be made
  task automatic test_empty_purse();
    send_request(ccmc_pkg::CMD_SOLVE, 3'd7, 6'd63, 6'd0);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd1);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd5, 6'd42, 6'd63);
  endtask

  // Smallest and largest coin, longest and shortest solutions
  task automatic test_coin_extremes();
    send_request(ccmc_pkg::CMD_LOAD, 3'd0, 6'd1, 6'd0);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd63);
    send_request(ccmc_pkg::CMD_LOAD, 3'd7, 6'd63, 6'd63);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd2, 6'd17, 6'd63);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd62);
  endtask

  // Non-greedy set, disabled slot, duplicate slot, coin above the amount
  task automatic test_known_sets();
    send_request(ccmc_pkg::CMD_LOAD, 3'd0, 6'd0, 6'd21);
    send_request(ccmc_pkg::CMD_LOAD, 3'd7, 6'd0, 6'd0);
    send_request(ccmc_pkg::CMD_LOAD, 3'd1, 6'd1, 6'd0);
    send_request(ccmc_pkg::CMD_LOAD, 3'd2, 6'd3, 6'd0);
    send_request(ccmc_pkg::CMD_LOAD, 3'd3, 6'd4, 6'd0);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd6);
    send_request(ccmc_pkg::CMD_LOAD, 3'd1, 6'd0, 6'd0);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd5);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd7);
    send_request(ccmc_pkg::CMD_LOAD, 3'd4, 6'd3, 6'd0);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd9);
    send_request(ccmc_pkg::CMD_LOAD, 3'd5, 6'd40, 6'd0);
    send_request(ccmc_pkg::CMD_SOLVE, 3'd0, 6'd0, 6'd2);
  endtask

  // Rounds of a few slot writes followed by a few solves, mostly small amounts
  task automatic test_random_change();
    int sent, loads, solves, r, n;
    logic [ccmc_pkg::COIN_W-1:0]   coin;
    logic [ccmc_pkg::AMT_IN_W-1:0] amount;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 150 && sent < 230);
      loads  = $urandom_range(0, 3);
      for (n = 0; n < loads; n++) begin
        r = $urandom_range(99);
        if (r < 15)      coin = '0;
        else if (r < 75) coin = ccmc_pkg::COIN_W'($urandom_range(1, 12));
        else             coin = ccmc_pkg::COIN_W'($urandom_range(1, 63));
        send_request(ccmc_pkg::CMD_LOAD, ccmc_pkg::SLOT_IN_W'($urandom_range(7)), coin,
                     ccmc_pkg::AMT_IN_W'($urandom_range(63)));
        sent++;
      end
      solves = $urandom_range(1, 4);
      for (n = 0; n < solves; n++) begin
        r = $urandom_range(99);
        if (r < 75)      amount = ccmc_pkg::AMT_IN_W'($urandom_range(0, 20));
        else if (r < 95) amount = ccmc_pkg::AMT_IN_W'($urandom_range(0, 63));
        else             amount = 6'd63;
        send_request(ccmc_pkg::CMD_SOLVE, ccmc_pkg::SLOT_IN_W'($urandom_range(7)),
                     ccmc_pkg::COIN_W'($urandom_range(63)), amount);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // Throttle the result side
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 8);
  end

  // Compare each accepted coin with the oldest expected one
  always @(posedge clk_i) begin : check_change
    change_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (change_q.size() == 0) begin
        $error("coin_out: unexpected result %0d (found %0b, last %0b)",
               coin_out_o, found_o, last_o);
        errors++;
      end else begin
        want = change_q.pop_front();
        if (coin_out_o !== want.coin) begin
          $error("coin_out: expected %0d, got %0d", want.coin, coin_out_o);
          errors++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("coin_change_min_coins_tb: errors");
      $finish;
    end
  end

  initial begin
    foreach (purse[k]) purse[k] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_purse();
    test_coin_extremes();
    test_known_sets();
    test_random_change();
    in_valid_i <= 1'b0;
    // Drain outstanding coins, then hold for stray results
    while (change_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("coin_change_min_coins_tb: clean");
    end else begin
      $display("coin_change_min_coins_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ccmc_pkg.sv
hw/rtl/ccmc_ram.sv
hw/rtl/ccmc_relax.sv
hw/rtl/coin_change_min_coins.sv
tb/sv/coin_change_min_coins_tb.sv
